### rtl/core/grab_pkg.sv
// Shared types, constants and command/status structs for the greedy route append builder.
package grab_pkg;

  localparam int unsigned MAX_NODES  = 64;
  localparam int unsigned MAX_TRUCKS = 16;
  localparam int unsigned DIST_BITS  = 16;

  localparam int unsigned NODE_W  = $clog2(MAX_NODES);
  localparam int unsigned TRUCK_W = $clog2(MAX_TRUCKS);
  localparam int unsigned DIST_AW = 2 * NODE_W;
  localparam int unsigned NN_W    = 7;
  localparam int unsigned NT_W    = 5;
  localparam int unsigned LOAD_W  = 23;
  localparam int unsigned LEN_W   = 7;
  localparam int unsigned INC_W   = DIST_BITS + 2;
  localparam int unsigned COST_W  = 32;
  localparam int unsigned ACC_W   = 38;
  localparam int unsigned PADDR_W = 4;
  localparam int unsigned PDATA_W = 32;

  typedef enum logic [1:0] {
    FUNC_LOAD_DIST = 2'd0,
    FUNC_LOAD_DEM  = 2'd1,
    FUNC_LOAD_CAP  = 2'd2,
    FUNC_BUILD     = 2'd3
  } func_e;

  typedef enum logic [1:0] {
    REG_NUM_NODES     = 2'd0,
    REG_NUM_TRUCKS    = 2'd1,
    REG_TRUCK_PENALTY = 2'd2
  } reg_idx_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CUST_A,
    ST_CUST_B,
    ST_CUST_C,
    ST_SCAN_RD,
    ST_SCAN_EV,
    ST_COMMIT,
    ST_SUM,
    ST_SUMMARY
  } state_e;

  typedef struct packed {
    logic [1:0]           func;
    logic [NODE_W-1:0]    row;
    logic [NODE_W-1:0]    col;
    logic [15:0]          value;
  } in_item_t;

  typedef struct packed {
    logic                 kind;
    logic [NODE_W-1:0]    node;
    logic [TRUCK_W-1:0]   truck;
    logic [NODE_W-1:0]    position;
    logic signed [31:0]   cost;
    logic [4:0]           active_trucks;
    logic                 infeasible;
    logic                 last;
  } out_item_t;

  typedef struct packed {
    logic [NN_W-1:0] num_nodes;
    logic [NT_W-1:0] num_trucks;
    logic [15:0]     truck_penalty;
  } cfg_t;

  typedef struct packed {
    logic idle;
    logic build_start;
    logic rd_cust0;
    logic rd_cust1;
    logic scan_init;
    logic scan_rd;
    logic scan_ev;
    logic commit;
    logic sum_init;
    logic sum_step;
    logic summary;
  } cmd_t;

  typedef struct packed {
    logic cust_done;
    logic truck_done;
    logic out_busy;
  } sts_t;

endpackage

### rtl/core/grab_cfg.sv
// APB-style register block holding the node count, truck count and truck penalty.
module grab_cfg import grab_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output logic               pready,
  output cfg_t               cfg_o
);

  cfg_t     cfg_q, cfg_d;
  reg_idx_e idx;
  logic     wr_en;

  assign idx    = reg_idx_e'(paddr[3:2]);
  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;
  assign cfg_o  = cfg_q;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      unique case (idx)
        REG_NUM_NODES:     cfg_d.num_nodes     = pwdata[NN_W-1:0];
        REG_NUM_TRUCKS:    cfg_d.num_trucks    = pwdata[NT_W-1:0];
        REG_TRUCK_PENALTY: cfg_d.truck_penalty = pwdata[15:0];
        default:           cfg_d = cfg_q;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_NUM_NODES:     prdata = PDATA_W'(cfg_q.num_nodes);
      REG_NUM_TRUCKS:    prdata = PDATA_W'(cfg_q.num_trucks);
      REG_TRUCK_PENALTY: prdata = PDATA_W'(cfg_q.truck_penalty);
      default:           prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.num_nodes     <= NN_W'(MAX_NODES);
      cfg_q.num_trucks    <= NT_W'(MAX_TRUCKS);
      cfg_q.truck_penalty <= '0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

endmodule

### rtl/core/grab_ctrl.sv
// Build sequencer: walks customers, scans trucks, commits results and sums the summary.
module grab_ctrl import grab_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  input  logic [1:0] in_func_i,
  input  sts_t       sts_i,
  output cmd_t       cmd_o
);

  state_e state_q, state_d;
  logic   start_build;

  assign start_build = in_valid_i && (func_e'(in_func_i) == FUNC_BUILD);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:    if (start_build) state_d = ST_CUST_A;
      ST_CUST_A:  state_d = sts_i.cust_done ? ST_SUM : ST_CUST_B;
      ST_CUST_B:  state_d = ST_CUST_C;
      ST_CUST_C:  state_d = ST_SCAN_RD;
      ST_SCAN_RD: state_d = sts_i.truck_done ? ST_COMMIT : ST_SCAN_EV;
      ST_SCAN_EV: state_d = ST_SCAN_RD;
      ST_COMMIT:  if (!sts_i.out_busy) state_d = ST_CUST_A;
      ST_SUM:     if (sts_i.truck_done) state_d = ST_SUMMARY;
      ST_SUMMARY: if (!sts_i.out_busy) state_d = ST_IDLE;
      default:    state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o = '0;
    unique case (state_q)
      ST_IDLE: begin
        cmd_o.idle        = 1'b1;
        cmd_o.build_start = start_build;
      end
      ST_CUST_A: begin
        cmd_o.rd_cust0 = !sts_i.cust_done;
        cmd_o.sum_init = sts_i.cust_done;
      end
      ST_CUST_B:  cmd_o.rd_cust1  = 1'b1;
      ST_CUST_C:  cmd_o.scan_init = 1'b1;
      ST_SCAN_RD: cmd_o.scan_rd   = !sts_i.truck_done;
      ST_SCAN_EV: cmd_o.scan_ev   = 1'b1;
      ST_COMMIT:  cmd_o.commit    = !sts_i.out_busy;
      ST_SUM:     cmd_o.sum_step  = !sts_i.truck_done;
      ST_SUMMARY: cmd_o.summary   = !sts_i.out_busy;
      default:    cmd_o = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

### rtl/core/grab_dp.sv
// Datapath: stores, route state, truck scan arithmetic, summary accumulator and result register.
module grab_dp import grab_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  cfg_t      cfg_i,
  input  cmd_t      cmd_i,
  output sts_t      sts_o,
  input  logic      in_valid_i,
  input  in_item_t  in_data_i,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output out_item_t out_data_o
);

  // stores
  logic [DIST_BITS-1:0] dist_mem [MAX_NODES*MAX_NODES];
  logic [15:0]          dem_mem  [MAX_NODES];
  logic [15:0]          cap_q    [MAX_TRUCKS];
  logic [DIST_BITS-1:0] dist_rd_q;
  logic [15:0]          dem_rd_q;

  // route state
  logic [LOAD_W-1:0]    route_load_q [MAX_TRUCKS];
  logic [NODE_W-1:0]    route_tail_q [MAX_TRUCKS];
  logic [LEN_W-1:0]     route_len_q  [MAX_TRUCKS];
  logic [COST_W-1:0]    route_cost_q [MAX_TRUCKS];
  logic [DIST_BITS-1:0] tail_back_q  [MAX_TRUCKS];
  logic [4:0]           active_q;
  logic                 any_inf_q;

  // per-customer and scan registers
  logic [NN_W-1:0]       u_q;
  logic [NT_W-1:0]       t_q;
  logic [DIST_BITS-1:0]  d0u_q;
  logic [DIST_BITS-1:0]  du0_q;
  logic                  found_q;
  logic signed [INC_W-1:0] best_q;
  logic [TRUCK_W-1:0]    best_t_q;
  logic signed [ACC_W-1:0] acc_q;

  logic      out_valid_q;
  out_item_t out_data_q;

  // combinational
  logic                  load_en;
  logic [NN_W-1:0]       nn;
  logic [NT_W-1:0]       nt;
  logic [TRUCK_W-1:0]    t_idx;
  logic [NODE_W-1:0]     u_idx;
  logic [DIST_AW-1:0]    rd_addr;
  logic                  rd_en;
  logic [LOAD_W-1:0]     load_sum;
  logic                  fits;
  logic [INC_W-1:0]      inc_raw;
  logic signed [INC_W-1:0] inc;
  logic                  take;
  logic                  empty_b;
  logic [COST_W-1:0]     best_ext;
  logic [COST_W:0]       cost_sum;
  logic [COST_W-1:0]     cost_sat;
  logic [20:0]           pen_prod;
  logic signed [ACC_W-1:0] total_sat;
  logic [4:0]            active_new;

  assign load_en = cmd_i.idle && in_valid_i;
  assign nn      = (cfg_i.num_nodes > NN_W'(MAX_NODES)) ? NN_W'(MAX_NODES) : cfg_i.num_nodes;
  assign nt      = (cfg_i.num_trucks > NT_W'(MAX_TRUCKS)) ? NT_W'(MAX_TRUCKS)
                                                          : cfg_i.num_trucks;
  assign t_idx   = t_q[TRUCK_W-1:0];
  assign u_idx   = u_q[NODE_W-1:0];

  assign sts_o.cust_done  = (u_q >= nn);
  assign sts_o.truck_done = (t_q >= nt);
  assign sts_o.out_busy   = out_valid_q && !out_ready_i;

  // distance read address: d(0,u), d(u,0) or d(tail,u)
  always_comb begin
    rd_en   = cmd_i.rd_cust0 || cmd_i.rd_cust1 || cmd_i.scan_rd;
    rd_addr = {route_tail_q[t_idx], u_idx};
    if (cmd_i.rd_cust0) begin
      rd_addr = {NODE_W'(0), u_idx};
    end else if (cmd_i.rd_cust1) begin
      rd_addr = {u_idx, NODE_W'(0)};
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_en && func_e'(in_data_i.func) == FUNC_LOAD_DIST) begin
      dist_mem[{in_data_i.row, in_data_i.col}] <= in_data_i.value[DIST_BITS-1:0];
    end
    if (rd_en) begin
      dist_rd_q <= dist_mem[rd_addr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_en && func_e'(in_data_i.func) == FUNC_LOAD_DEM) begin
      dem_mem[in_data_i.row] <= in_data_i.value;
    end
    if (cmd_i.rd_cust0) begin
      dem_rd_q <= dem_mem[u_idx];
    end
  end

  // drop capacity loads beyond the truck range
  always_ff @(posedge clk_i) begin
    if (load_en && func_e'(in_data_i.func) == FUNC_LOAD_CAP &&
        in_data_i.row[NODE_W-1:TRUCK_W] == '0) begin
      cap_q[in_data_i.row[TRUCK_W-1:0]] <= in_data_i.value;
    end
  end

  // scan evaluation for truck t
  always_comb begin
    load_sum = route_load_q[t_idx] + LOAD_W'(dem_rd_q);
    fits     = load_sum <= LOAD_W'(cap_q[t_idx]);
    if (route_len_q[t_idx] == '0) begin
      inc_raw = {1'b0, d0u_q, 1'b0};
    end else begin
      inc_raw = INC_W'(dist_rd_q) + INC_W'(du0_q) - INC_W'(tail_back_q[t_idx]);
    end
    inc  = signed'(inc_raw);
    take = fits && (!found_q || inc < best_q);
  end

  // commit arithmetic for the chosen truck
  always_comb begin
    empty_b    = (route_len_q[best_t_q] == '0);
    best_ext   = COST_W'(best_q);
    cost_sum   = {route_cost_q[best_t_q][COST_W-1], route_cost_q[best_t_q]} +
                 {best_ext[COST_W-1], best_ext};
    if (cost_sum[COST_W] != cost_sum[COST_W-1]) begin
      cost_sat = cost_sum[COST_W] ? {1'b1, {(COST_W-1){1'b0}}} : {1'b0, {(COST_W-1){1'b1}}};
    end else begin
      cost_sat = cost_sum[COST_W-1:0];
    end
    active_new = active_q + {4'd0, empty_b};
    pen_prod   = 21'(cfg_i.truck_penalty) * 21'(active_q);
    if (acc_q > ACC_W'(signed'(32'sh7FFF_FFFF))) begin
      total_sat = ACC_W'(signed'(32'sh7FFF_FFFF));
    end else if (acc_q < ACC_W'(signed'(32'sh8000_0000))) begin
      total_sat = ACC_W'(signed'(32'sh8000_0000));
    end else begin
      total_sat = acc_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < MAX_TRUCKS; i++) begin
        route_load_q[i] <= '0;
        route_tail_q[i] <= '0;
        route_len_q[i]  <= '0;
        route_cost_q[i] <= '0;
        tail_back_q[i]  <= '0;
      end
      active_q  <= '0;
      any_inf_q <= 1'b0;
    end else if (cmd_i.build_start) begin
      for (int i = 0; i < MAX_TRUCKS; i++) begin
        route_load_q[i] <= '0;
        route_tail_q[i] <= '0;
        route_len_q[i]  <= '0;
        route_cost_q[i] <= '0;
        tail_back_q[i]  <= '0;
      end
      active_q  <= '0;
      any_inf_q <= 1'b0;
    end else if (cmd_i.commit) begin
      if (found_q) begin
        route_cost_q[best_t_q] <= empty_b ? best_ext : cost_sat;
        route_tail_q[best_t_q] <= u_idx;
        route_len_q[best_t_q]  <= route_len_q[best_t_q] + LEN_W'(1);
        route_load_q[best_t_q] <= route_load_q[best_t_q] + LOAD_W'(dem_rd_q);
        tail_back_q[best_t_q]  <= du0_q;
        active_q               <= active_new;
      end else begin
        any_inf_q <= 1'b1;
      end
    end
  end

  // customer and truck counters, scan best
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      u_q     <= '0;
      t_q     <= '0;
      found_q <= 1'b0;
    end else begin
      if (cmd_i.build_start) begin
        u_q <= NN_W'(1);
      end else if (cmd_i.commit) begin
        u_q <= u_q + NN_W'(1);
      end
      if (cmd_i.scan_init || cmd_i.sum_init) begin
        t_q <= '0;
      end else if (cmd_i.scan_ev || cmd_i.sum_step) begin
        t_q <= t_q + NT_W'(1);
      end
      if (cmd_i.scan_init) begin
        found_q <= 1'b0;
      end else if (cmd_i.scan_ev && take) begin
        found_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.rd_cust1) begin
      d0u_q <= dist_rd_q;
    end
    if (cmd_i.scan_init) begin
      du0_q <= dist_rd_q;
    end
    if (cmd_i.scan_ev && take) begin
      best_q   <= inc;
      best_t_q <= t_idx;
    end
    // start from the penalty term, then add route costs one truck a cycle
    if (cmd_i.sum_init) begin
      acc_q <= ACC_W'(pen_prod);
    end else if (cmd_i.sum_step) begin
      acc_q <= acc_q + ACC_W'(signed'(route_cost_q[t_idx]));
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.commit || cmd_i.summary) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.commit) begin
      out_data_q.kind          <= 1'b0;
      out_data_q.node          <= u_idx;
      out_data_q.truck         <= found_q ? best_t_q : '0;
      out_data_q.position      <= found_q ? route_len_q[best_t_q][NODE_W-1:0] : '0;
      out_data_q.cost          <= found_q ? signed'(best_ext) : '0;
      out_data_q.active_trucks <= found_q ? active_new : active_q;
      out_data_q.infeasible    <= !found_q;
      out_data_q.last          <= 1'b0;
    end else if (cmd_i.summary) begin
      out_data_q.kind          <= 1'b1;
      out_data_q.node          <= '0;
      out_data_q.truck         <= '0;
      out_data_q.position      <= '0;
      out_data_q.cost          <= signed'(total_sat[COST_W-1:0]);
      out_data_q.active_trucks <= active_q;
      out_data_q.infeasible    <= any_inf_q;
      out_data_q.last          <= 1'b1;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

### rtl/core/greedy_route_append_builder_core.sv
// Greedy cheapest-append route builder: a load and build engine for capacitated routing.
// Load items (distance, demand, capacity) transfer one per clock while the block is idle and
// give no result. A build item starts a run that places customers 1 to N-1 in order on the
// feasible truck with the cheapest append cost (lowest index on a tie), gives one assignment
// result per customer and then a summary with last set. Input stays stalled for the whole run,
// which also waits whenever the output side holds back a result. The truck scan reads the
// single read port of the distance memory for one truck and then evaluates it, truck by truck;
// the summary then adds up route costs one truck per cycle. Configuration reads and writes go
// through the APB port at offsets 0x0 (num_nodes), 0x4 (num_trucks) and 0x8 (truck_penalty).
module greedy_route_append_builder_core import grab_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  in_item_t           in_data_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output out_item_t          out_data_o,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output logic               pready
);

  cfg_t cfg;
  cmd_t cmd;
  sts_t sts;

  grab_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  grab_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_func_i  (in_data_i.func),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  grab_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .in_valid_i  (in_valid_i),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

  assign in_ready_o = cmd.idle;

endmodule
